// File: sv/a85_pkg.sv
package a85_pkg;

   localparam logic [7:0] A85_BASE       = 8'd85;
   localparam logic [7:0] A85_OFFSET     = 8'd33;
   localparam logic [7:0] A85_ZERO_CHAR  = 8'd122;
   localparam logic [7:0] A85_NEWLINE    = 8'd10;
   localparam logic [7:0] A85_MIN_LINE   = 8'd5;
   localparam logic [7:0] A85_RESET_LINE = 8'd72;
   localparam logic [7:0] A85_LAST_DIGIT = 8'd117;

   // Reciprocal of 85 scaled by 2^38; exact quotient for any 32-bit dividend.
   localparam logic [31:0] A85_RECIP      = 32'd3233857729;
   localparam int          A85_RECIP_SHIFT = 38;
   localparam int          A85_QUOT_WIDTH  = 26;

   localparam int          A85_DIGITS     = 5;

   localparam logic        A85_OP_DATA    = 1'b0;
   localparam logic        A85_OP_FLUSH   = 1'b1;

   // One unit of work handed from the front to the back.
   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  nchars;
      logic        zero;
      logic        flush;
   } a85_job_type;

endpackage

// File: sv/a85_if.sv
interface a85_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] data_byte;

   modport source (output valid, output op, output data_byte, input ready);
   modport sink (input valid, input op, input data_byte, output ready);
endinterface

interface a85_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last;

   modport source (output valid, output out_char, output last, input ready);
   modport sink (input valid, input out_char, input last, output ready);
endinterface

// File: sv/a85_front.sv
module a85_front (
   input  logic                 clock,
   input  logic                 reset,
   a85_req_if.sink              req_ch,
   input  logic                 q_full,
   output logic                 q_push,
   output a85_pkg::a85_job_type q_job
);

   logic [23:0] tuple_ff, tuple_in;
   logic [1:0]  count_ff, count_in;
   logic        fire;
   logic [31:0] word;

   assign req_ch.ready = !q_full;
   assign fire = req_ch.valid && req_ch.ready;
   assign q_push = fire && ((req_ch.op == a85_pkg::A85_OP_FLUSH) || (count_ff == 2'd3));

   assign word = {tuple_ff, (req_ch.op == a85_pkg::A85_OP_FLUSH) ? 8'h00 : req_ch.data_byte};

   always_comb begin
      q_job.word  = word;
      q_job.flush = (req_ch.op == a85_pkg::A85_OP_FLUSH);
      if (req_ch.op == a85_pkg::A85_OP_FLUSH) begin
         q_job.zero   = 1'b0;
         q_job.nchars = (count_ff == 2'd0) ? 3'd0 : ({1'b0, count_ff} + 3'd1);
      end else begin
         q_job.zero   = (word == 32'd0);
         q_job.nchars = (word == 32'd0) ? 3'd1 : 3'(a85_pkg::A85_DIGITS);
      end
   end

   always_comb begin
      tuple_in = tuple_ff;
      count_in = count_ff;
      if (fire) begin
         if ((req_ch.op == a85_pkg::A85_OP_DATA) && (count_ff != 2'd3)) begin
            case (count_ff)
               2'd0:    tuple_in[23:16] = req_ch.data_byte;
               2'd1:    tuple_in[15:8]  = req_ch.data_byte;
               default: tuple_in[7:0]   = req_ch.data_byte;
            endcase
            count_in = count_ff + 2'd1;
         end else begin
            tuple_in = 24'd0;
            count_in = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tuple_ff <= 24'd0;
         count_ff <= 2'd0;
      end else begin
         tuple_ff <= tuple_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: sv/a85_fifo.sv
module a85_fifo #(
   parameter int Depth = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  a85_pkg::a85_job_type push_data,
   output logic                 full,
   input  logic                 pop,
   output a85_pkg::a85_job_type pop_data,
   output logic                 nonempty
);

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntWidth = $clog2(Depth + 1);

   a85_pkg::a85_job_type slot_ff [Depth];
   logic [PtrWidth-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CntWidth-1:0]  count_ff;
   logic                 do_push, do_pop;

   assign full     = (count_ff == CntWidth'(Depth));
   assign nonempty = (count_ff != '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && nonempty;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// File: sv/a85_back.sv
module a85_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  a85_pkg::a85_job_type q_job,
   output logic                 q_pop,
   input  logic [7:0]           line_length,
   a85_rsp_if.source            rsp_ch
);

   localparam int QW = a85_pkg::A85_QUOT_WIDTH;
   localparam int ND = a85_pkg::A85_DIGITS;

   // Converter: one base-85 digit per cycle, least significant first.
   logic                 conv_busy_ff, conv_busy_in;
   logic                 res_valid_ff, res_valid_in;
   logic [2:0]           conv_cnt_ff, conv_cnt_in;
   logic [31:0]          val_ff;
   logic [QW-1:0]        quot_ff;
   logic [7:0]           dig_ff [ND];
   a85_pkg::a85_job_type meta_ff;
   logic [31:0]          mul_a;
   logic [63:0]          product;
   logic [6:0]           q85_lo;
   logic [6:0]           rem;
   logic [7:0]           digit_char;
   logic                 conv_take;

   // Emitter: one character per cycle into the output register while the output is not stalled.
   logic                 em_busy_ff, em_busy_in;
   logic [7:0]           em_dig_ff [ND];
   logic [2:0]           em_nchars_ff;
   logic                 em_zero_ff, em_flush_ff;
   logic [2:0]           em_idx_ff, em_idx_in;
   logic                 nl_pend_ff, nl_pend_in;
   logic [7:0]           col_ff, col_in;
   logic                 em_load, step;
   logic [7:0]           eff_len, col_plus;
   logic [2:0]           sel;
   logic                 emit, emit_last;
   logic [7:0]           emit_char;
   logic                 out_valid_ff;
   logic [7:0]           out_char_ff;
   logic                 out_last_ff;

   assign conv_take = q_valid && !conv_busy_ff && !res_valid_ff;
   assign q_pop     = conv_take;

   assign mul_a   = conv_take ? q_job.word : 32'(quot_ff);
   assign product = mul_a * a85_pkg::A85_RECIP;

   // Only the low seven bits of value minus 85 times quotient are needed.
   assign q85_lo = {quot_ff[0], 6'b0} + {quot_ff[2:0], 4'b0} + {quot_ff[4:0], 2'b0}
                 + quot_ff[6:0];
   assign rem        = val_ff[6:0] - q85_lo;
   assign digit_char = {1'b0, rem} + a85_pkg::A85_OFFSET;

   assign em_load = res_valid_ff && !em_busy_ff;

   always_comb begin
      conv_busy_in = conv_busy_ff;
      res_valid_in = res_valid_ff;
      conv_cnt_in  = conv_cnt_ff;
      if (conv_take) begin
         conv_busy_in = 1'b1;
         conv_cnt_in  = 3'(ND - 1);
      end else if (conv_busy_ff) begin
         if (conv_cnt_ff == 3'd0) begin
            conv_busy_in = 1'b0;
            res_valid_in = 1'b1;
         end else begin
            conv_cnt_in = conv_cnt_ff - 3'd1;
         end
      end else if (em_load) begin
         res_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         conv_busy_ff <= 1'b0;
         res_valid_ff <= 1'b0;
         conv_cnt_ff  <= 3'd0;
      end else begin
         conv_busy_ff <= conv_busy_in;
         res_valid_ff <= res_valid_in;
         conv_cnt_ff  <= conv_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (conv_take) begin
         val_ff  <= q_job.word;
         quot_ff <= product[a85_pkg::A85_RECIP_SHIFT +: QW];
         meta_ff <= q_job;
      end else if (conv_busy_ff) begin
         dig_ff[conv_cnt_ff] <= digit_char;
         val_ff  <= 32'(quot_ff);
         quot_ff <= product[a85_pkg::A85_RECIP_SHIFT +: QW];
      end
   end

   assign eff_len  = (line_length < a85_pkg::A85_MIN_LINE) ? a85_pkg::A85_MIN_LINE
                                                           : line_length;
   assign col_plus = col_ff + 8'd1;
   assign sel      = (em_idx_ff > 3'(ND - 1)) ? 3'(ND - 1) : em_idx_ff;
   assign step     = em_busy_ff && (!out_valid_ff || rsp_ch.ready);

   always_comb begin
      emit       = 1'b0;
      emit_char  = a85_pkg::A85_NEWLINE;
      emit_last  = 1'b0;
      em_busy_in = em_busy_ff;
      em_idx_in  = em_idx_ff;
      nl_pend_in = nl_pend_ff;
      col_in     = col_ff;
      if (em_load) begin
         em_busy_in = 1'b1;
         em_idx_in  = 3'd0;
         nl_pend_in = 1'b0;
      end else if (step) begin
         if (nl_pend_ff) begin
            emit       = 1'b1;
            col_in     = 8'd0;
            nl_pend_in = 1'b0;
            if (em_idx_ff == em_nchars_ff) begin
               emit_last  = 1'b1;
               em_busy_in = 1'b0;
            end
         end else if (em_idx_ff < em_nchars_ff) begin
            emit      = 1'b1;
            emit_char = em_zero_ff ? a85_pkg::A85_ZERO_CHAR : em_dig_ff[sel];
            em_idx_in = em_idx_ff + 3'd1;
            if (col_plus >= eff_len) begin
               nl_pend_in = 1'b1;
               col_in     = 8'd0;
            end else begin
               col_in = col_plus;
               if ((em_idx_in == em_nchars_ff) && !(em_flush_ff && (col_plus != 8'd0))) begin
                  emit_last  = 1'b1;
                  em_busy_in = 1'b0;
               end
            end
         end else begin
            // A flush ends a non-empty line; otherwise the job has nothing left.
            em_busy_in = 1'b0;
            if (em_flush_ff && (col_ff != 8'd0)) begin
               emit      = 1'b1;
               emit_last = 1'b1;
               col_in    = 8'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         em_busy_ff   <= 1'b0;
         em_idx_ff    <= 3'd0;
         nl_pend_ff   <= 1'b0;
         col_ff       <= 8'd0;
         out_valid_ff <= 1'b0;
      end else begin
         em_busy_ff <= em_busy_in;
         em_idx_ff  <= em_idx_in;
         nl_pend_ff <= nl_pend_in;
         col_ff     <= col_in;
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (em_load) begin
         em_dig_ff    <= dig_ff;
         em_nchars_ff <= meta_ff.nchars;
         em_zero_ff   <= meta_ff.zero;
         em_flush_ff  <= meta_ff.flush;
      end
      if (emit) begin
         out_char_ff <= emit_char;
         out_last_ff <= emit_last;
      end
   end

   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.out_char = out_char_ff;
   assign rsp_ch.last     = out_last_ff;

endmodule

// File: sv/ascii85_line_wrapped_encoder_top.sv
// Output: only a tuple-completing byte or a flush can give output; bytes that do not
// complete a tuple give none.
// Throughput: up to one character per cycle within a tuple unless the output stalls; the
// back end's five-step divide-by-85 loop takes a tuple only once the emitter has the last one.
// Reset: synchronous, active high; clears the tuple, column, queue and handshake state
// and sets the line length to 72.
module ascii85_line_wrapped_encoder_top #(
   parameter int QueueDepth = 2
) (
   input  logic       clock,
   input  logic       reset,
   a85_req_if.sink    req_ch,
   a85_rsp_if.source  rsp_ch,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   logic                 q_full, q_push, q_pop, q_valid;
   a85_pkg::a85_job_type push_job, pop_job;
   logic [7:0]           line_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff <= a85_pkg::A85_RESET_LINE;
      end else if (csr_wr_en) begin
         line_length_ff <= csr_wr_data;
      end
   end

   a85_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_job  (push_job)
   );

   a85_fifo #(
      .Depth (QueueDepth)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_job),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_job),
      .nonempty  (q_valid)
   );

   a85_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_job       (pop_job),
      .q_pop       (q_pop),
      .line_length (line_length_ff),
      .rsp_ch      (rsp_ch)
   );

endmodule

// File: sv/a85_checker.sv
module a85_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_char,
   input logic       rsp_last
);

   logic prev_nl_ff;

   // Remembers whether the last transferred character was a newline.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_nl_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         prev_nl_ff <= (rsp_out_char == a85_pkg::A85_NEWLINE);
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char) && $stable(rsp_last))
      else $error("result changed while stalled");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   a_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_char == a85_pkg::A85_NEWLINE)
                 || (rsp_out_char == a85_pkg::A85_ZERO_CHAR)
                 || ((rsp_out_char >= a85_pkg::A85_OFFSET)
                     && (rsp_out_char <= a85_pkg::A85_LAST_DIGIT)))
      else $error("character outside the output alphabet");

   a_no_blank_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(prev_nl_ff && (rsp_out_char == a85_pkg::A85_NEWLINE)))
      else $error("two newlines in a row");

endmodule

bind ascii85_line_wrapped_encoder_top a85_checker u_a85_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_out_char (rsp_ch.out_char),
   .rsp_last     (rsp_ch.last)
);
